FILE: hdl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types, register codes and sizes for the looping cubic resampler.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int unsigned SOURCE_DEPTH_DEF = 65536;
  localparam int unsigned SAMPLE_BITS_DEF  = 16;

  localparam int unsigned POS_W     = 33;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned PADDR_W   = 5;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SETPOS = 2'd1,
    ACT_RENDER = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_SPEED_STEP    = 3'd0,
    REG_LOOP_ENABLE   = 3'd1,
    REG_LOOP_START    = 3'd2,
    REG_LOOP_END      = 3'd3,
    REG_SOURCE_LENGTH = 3'd4,
    REG_MONO_SOURCE   = 3'd5,
    REG_GAIN_LEFT     = 3'd6,
    REG_GAIN_RIGHT    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [24:0] speed_step;
    logic               loop_enable;
    logic [15:0]        loop_start;
    logic [16:0]        loop_end;
    logic [16:0]        source_length;
    logic               mono_source;
    logic [15:0]        gain_left;
    logic [15:0]        gain_right;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DSP,
    S_WRAP,
    S_OUT
  } top_state_e;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL,
    D_ADD,
    D_GAIN,
    D_MIX,
    D_DONE
  } dsp_state_e;

  typedef enum logic [1:0] {
    W_IDLE,
    W_DIV,
    W_FIX,
    W_DONE
  } wrap_state_e;

endpackage

FILE: hdl/lcr_regs.sv
// ----------------------------------------------------------------------------
// lcr_regs
// Configuration register file behind an APB-style slave port.
// ----------------------------------------------------------------------------
module lcr_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lcr_pkg::cfg_t               cfg_o
);
  import lcr_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;

  // Registers sit on word addresses, so the two low address bits carry no code.
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_step    <= 25'sd65536;
      cfg_q.loop_enable   <= 1'b0;
      cfg_q.loop_start    <= 16'd0;
      cfg_q.loop_end      <= 17'd65536;
      cfg_q.source_length <= 17'd0;
      cfg_q.mono_source   <= 1'b0;
      cfg_q.gain_left     <= 16'd16384;
      cfg_q.gain_right    <= 16'd16384;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_SPEED_STEP:    cfg_q.speed_step    <= $signed(pwdata[24:0]);
        REG_LOOP_ENABLE:   cfg_q.loop_enable   <= pwdata[0];
        REG_LOOP_START:    cfg_q.loop_start    <= pwdata[15:0];
        REG_LOOP_END:      cfg_q.loop_end      <= pwdata[16:0];
        REG_SOURCE_LENGTH: cfg_q.source_length <= pwdata[16:0];
        REG_MONO_SOURCE:   cfg_q.mono_source   <= pwdata[0];
        REG_GAIN_LEFT:     cfg_q.gain_left     <= pwdata[15:0];
        REG_GAIN_RIGHT:    cfg_q.gain_right    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPEED_STEP:    prdata = 32'(cfg_q.speed_step);
      REG_LOOP_ENABLE:   prdata = {31'd0, cfg_q.loop_enable};
      REG_LOOP_START:    prdata = {16'd0, cfg_q.loop_start};
      REG_LOOP_END:      prdata = {15'd0, cfg_q.loop_end};
      REG_SOURCE_LENGTH: prdata = {15'd0, cfg_q.source_length};
      REG_MONO_SOURCE:   prdata = {31'd0, cfg_q.mono_source};
      REG_GAIN_LEFT:     prdata = {16'd0, cfg_q.gain_left};
      REG_GAIN_RIGHT:    prdata = {16'd0, cfg_q.gain_right};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

FILE: hdl/lcr_store.sv
// ----------------------------------------------------------------------------
// lcr_store
// Single-port synchronous sample store holding left and right side by side.
// ----------------------------------------------------------------------------
module lcr_store #(
  parameter  int unsigned DEPTH  = lcr_pkg::SOURCE_DEPTH_DEF,
  parameter  int unsigned WIDTH  = 2 * lcr_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lcr_wrap.sv
// ----------------------------------------------------------------------------
// lcr_wrap
// Folds a Q17.16 position into the loop region with a serial remainder unit.
// ----------------------------------------------------------------------------
module lcr_wrap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [lcr_pkg::POS_W-1:0]  pos_i,
  input  lcr_pkg::cfg_t                     cfg_i,
  output logic                              done_o,
  output logic signed [lcr_pkg::POS_W-1:0]  pos_o
);
  import lcr_pkg::*;

  wrap_state_e state_q, state_d;

  logic signed [17:0] len, x;
  logic               active, in_loop;
  logic [16:0]        mag;
  logic [17:0]        r2;
  logic [16:0]        rem_q, mag_q, len_q, ls_q, fixed;
  logic [4:0]         cnt_q;
  logic               neg_q;
  logic [FRAC_W-1:0]  frac_q;
  logic signed [POS_W-1:0] pos_q;

  assign len     = $signed({1'b0, cfg_i.loop_end}) - $signed({2'b00, cfg_i.loop_start});
  assign x       = $signed({pos_i[POS_W-1], pos_i[POS_W-1:FRAC_W]})
                 - $signed({2'b00, cfg_i.loop_start});
  assign active  = cfg_i.loop_enable && (len > 18'sd1);
  assign in_loop = !x[17] && (x < len);
  assign mag     = x[17] ? 17'(-x) : x[16:0];
  assign r2      = {rem_q, mag_q[16]};
  // Floored modulo: a negative offset with a remainder folds back from the top.
  assign fixed   = (neg_q && (rem_q != 17'd0)) ? (len_q - rem_q) : rem_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          if (!active)      state_d = W_DONE;
          else if (in_loop) state_d = W_FIX;
          else              state_d = W_DIV;
        end
      end
      W_DIV:  if (cnt_q == 5'd1) state_d = W_FIX;
      W_FIX:  state_d = W_DONE;
      W_DONE: state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == W_DONE);
    pos_o  = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          pos_q  <= pos_i;
          frac_q <= pos_i[FRAC_W-1:0];
          len_q  <= len[16:0];
          ls_q   <= {1'b0, cfg_i.loop_start};
          mag_q  <= mag;
          cnt_q  <= 5'(DIV_STEPS);
          if (in_loop) begin
            rem_q <= x[16:0];
            neg_q <= 1'b0;
          end else begin
            rem_q <= 17'd0;
            neg_q <= x[17];
          end
        end
      end
      W_DIV: begin
        if (r2 >= {1'b0, len_q}) rem_q <= 17'(r2 - {1'b0, len_q});
        else                     rem_q <= r2[16:0];
        mag_q <= {mag_q[15:0], 1'b0};
        cnt_q <= cnt_q - 5'd1;
      end
      W_FIX:  pos_q <= $signed({ls_q + fixed, frac_q});
      default: ;
    endcase
  end

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == W_IDLE && start_i |=> state_q != W_IDLE)
    else $error("wrap unit ignored a start");

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == W_DIV || state_q == W_FIX) |-> rem_q < len_q)
    else $error("partial remainder reached the loop length");

  a_result_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) == W_FIX && state_q == W_DONE
      |-> pos_q[POS_W-1:FRAC_W] >= ls_q && pos_q[POS_W-1:FRAC_W] < ls_q + len_q)
    else $error("wrapped position left the loop region");

endmodule

FILE: hdl/lcr_dsp.sv
// ----------------------------------------------------------------------------
// lcr_dsp
// Catmull-Rom Horner evaluation, gain and saturating mix for both channels.
// ----------------------------------------------------------------------------
module lcr_dsp #(
  parameter int unsigned SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] y_l_i [4],
  input  logic signed [SAMPLE_BITS-1:0] y_r_i [4],
  input  logic [lcr_pkg::FRAC_W-1:0]    frac_i,
  input  lcr_pkg::cfg_t                 cfg_i,
  input  logic signed [15:0]            mix_l_i,
  input  logic signed [15:0]            mix_r_i,
  output logic                          done_o,
  output logic signed [15:0]            out_l_o,
  output logic signed [15:0]            out_r_o,
  output logic                          clip_o
);
  import lcr_pkg::*;

  localparam int unsigned AW = SAMPLE_BITS + 6;
  localparam int unsigned PW = AW + 17;
  localparam logic signed [PW-1:0] RND16  = PW'(32768);
  localparam logic signed [PW-1:0] RNDG   = PW'(64'sd1 <<< (SAMPLE_BITS - 3));
  localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
  localparam logic signed [PW-1:0] SAT_LO = -PW'(32768);

  dsp_state_e state_q, state_d;

  logic signed [AW-1:0] ye [2][4];
  logic signed [AW-1:0] c1 [2], c2 [2], c3 [2], d12 [2];
  logic signed [AW-1:0] a_q [2], c1_q [2], c2_q [2], y1x2_q [2];
  logic signed [AW-1:0] addend [2], v [2];
  logic signed [PW-1:0] p_q [2], g_q [2], s [2];
  logic [1:0]           iter_q;
  logic [15:0]          gain [2];
  logic signed [15:0]   mix [2];
  logic signed [15:0]   sat [2];
  logic                 ovf [2];

  assign gain[0] = cfg_i.gain_left;
  assign gain[1] = cfg_i.gain_right;
  assign mix[0]  = mix_l_i;
  assign mix[1]  = mix_r_i;

  // Doubled coefficients, so the final value needs one rounding halving.
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      for (int k = 0; k < 4; k++) begin
        ye[ch][k] = (ch == 0) ? AW'(y_l_i[k]) : AW'(y_r_i[k]);
      end
      d12[ch] = ye[ch][1] - ye[ch][2];
      c1[ch]  = ye[ch][2] - ye[ch][0];
      c2[ch]  = (ye[ch][0] <<< 1) - ((ye[ch][1] <<< 2) + ye[ch][1])
              + (ye[ch][2] <<< 2) - ye[ch][3];
      c3[ch]  = ye[ch][3] - ye[ch][0] + d12[ch] + (d12[ch] <<< 1);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      case (iter_q)
        2'd0:    addend[ch] = c2_q[ch];
        2'd1:    addend[ch] = c1_q[ch];
        default: addend[ch] = y1x2_q[ch];
      endcase
    end
    v[0] = AW'((a_q[0] + AW'(1)) >>> 1);
    v[1] = cfg_i.mono_source ? v[0] : AW'((a_q[1] + AW'(1)) >>> 1);
    for (int ch = 0; ch < 2; ch++) begin
      s[ch]   = ((g_q[ch] + RNDG) >>> (SAMPLE_BITS - 2)) + PW'(mix[ch]);
      ovf[ch] = (s[ch] > SAT_HI) || (s[ch] < SAT_LO);
      if (s[ch] > SAT_HI)      sat[ch] = 16'sh7fff;
      else if (s[ch] < SAT_LO) sat[ch] = -16'sh8000;
      else                     sat[ch] = s[ch][15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE: if (start_i) state_d = D_MUL;
      D_MUL:  state_d = D_ADD;
      D_ADD:  state_d = (iter_q == 2'd2) ? D_GAIN : D_MUL;
      D_GAIN: state_d = D_MIX;
      D_MIX:  state_d = D_DONE;
      D_DONE: state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == D_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          for (int ch = 0; ch < 2; ch++) begin
            a_q[ch]    <= c3[ch];
            c1_q[ch]   <= c1[ch];
            c2_q[ch]   <= c2[ch];
            y1x2_q[ch] <= ye[ch][1] <<< 1;
          end
          iter_q <= 2'd0;
        end
      end
      D_MUL: begin
        for (int ch = 0; ch < 2; ch++) begin
          p_q[ch] <= a_q[ch] * $signed({1'b0, frac_i});
        end
      end
      D_ADD: begin
        for (int ch = 0; ch < 2; ch++) begin
          a_q[ch] <= AW'((p_q[ch] + RND16) >>> 16) + addend[ch];
        end
        iter_q <= iter_q + 2'd1;
      end
      D_GAIN: begin
        for (int ch = 0; ch < 2; ch++) begin
          g_q[ch] <= PW'(v[ch]) * PW'($signed({1'b0, gain[ch]}));
        end
      end
      D_MIX: begin
        out_l_o <= sat[0];
        out_r_o <= sat[1];
        clip_o  <= ovf[0] || ovf[1];
      end
      default: ;
    endcase
  end

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == D_IDLE)
    else $error("interpolator started while busy");

  a_three_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == D_GAIN |-> iter_q == 2'd3)
    else $error("Horner evaluation skipped a step");

  a_done_after_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == D_DONE |-> $past(state_q) == D_MIX)
    else $error("done raised without a mix step");

endmodule

FILE: hdl/looping_cubic_resampler_core.sv
// ----------------------------------------------------------------------------
// looping_cubic_resampler_core
// Stereo looping sample player with cubic Hermite interpolation and mixing.
// ----------------------------------------------------------------------------
// A load item writes one stereo sample into the store as it is accepted. A
// set-position item goes to the wrap unit, which passes the position through
// when looping is off or the loop is too short to wrap, and otherwise folds it
// back with the 17-step serial remainder unit when it lies outside the loop
// region. A render item reads its four neighboring stereo samples one after
// another from the single-port sample store, runs the repeated Horner
// multiply-add steps, gain and mix, then advances the position through the
// same wrap unit and registers its result. One item is in flight at a time; a
// finished result waits in the output register while the next item is taken,
// and a render that finds the previous result still waiting holds until that
// result is taken.
// ----------------------------------------------------------------------------
module looping_cubic_resampler_core #(
  parameter int unsigned SOURCE_DEPTH = lcr_pkg::SOURCE_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS  = lcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [15:0]                 sample_address_i,
  input  logic signed [15:0]          load_left_i,
  input  logic signed [15:0]          load_right_i,
  input  logic signed [32:0]          start_position_i,
  input  logic signed [15:0]          mix_left_i,
  input  logic signed [15:0]          mix_right_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [15:0]          out_left_o,
  output logic signed [15:0]          out_right_o,
  output logic                        clipped_o
);
  import lcr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(SOURCE_DEPTH);
  localparam int unsigned SB     = SAMPLE_BITS;

  function automatic logic signed [SB-1:0] to_store(input logic signed [15:0] x);
    logic signed [47:0] w;
    begin
      w = 48'(x) <<< 16;
      to_store = SB'(w >>> (32 - SB));
    end
  endfunction

  cfg_t       cfg;
  top_state_e state_q, state_d;
  action_e    act;

  logic in_acc, store_en, store_we, ld_ok, rd_ok, rd_issue, dsp_start, out_load;
  logic [31:0] ld_addr32, rd_addr32, len32;
  logic [ADDR_W-1:0] store_addr;
  logic [2*SB-1:0]   rdata;
  logic signed [17:0] rd_idx;
  logic [2:0]  cnt_q;
  logic [1:0]  slot_q;
  logic        slot_ok_q, pend_q, render_q, out_valid_q;
  logic signed [SB-1:0] y_l_q [4], y_r_q [4];
  logic signed [15:0]   mix_l_q, mix_r_q;
  logic signed [POS_W-1:0] pos_q, np_sat, wrap_in, wrap_out;
  logic signed [POS_W:0]   np;
  logic wrap_start, wrap_done, dsp_done, dsp_clip;
  logic signed [15:0] dsp_l, dsp_r;

  lcr_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign act       = action_e'(action_i);
  assign in_acc    = in_valid_i && in_ready_o;
  assign ld_addr32 = 32'(sample_address_i);
  assign ld_ok     = ld_addr32 < 32'(SOURCE_DEPTH);
  assign store_we  = in_acc && (act == ACT_LOAD) && ld_ok;

  // Neighbor index floor(pos)-1 .. floor(pos)+2, picked by the read counter.
  assign rd_idx    = $signed({pos_q[POS_W-1], pos_q[POS_W-1:FRAC_W]})
                   + $signed({16'd0, cnt_q[1:0]}) - 18'sd1;
  assign rd_addr32 = 32'(rd_idx[16:0]);
  assign len32     = 32'(cfg.source_length);
  assign rd_ok     = !rd_idx[17] && (rd_addr32 < len32) && (rd_addr32 < 32'(SOURCE_DEPTH));
  assign store_addr = store_we ? ld_addr32[ADDR_W-1:0] : rd_addr32[ADDR_W-1:0];

  lcr_store #(
    .DEPTH(SOURCE_DEPTH),
    .WIDTH(2 * SB)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (store_en),
    .we_i   (store_we),
    .addr_i (store_addr),
    .wdata_i({to_store(load_left_i), to_store(load_right_i)}),
    .rdata_o(rdata)
  );

  lcr_dsp #(
    .SAMPLE_BITS(SB)
  ) u_dsp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dsp_start),
    .y_l_i  (y_l_q),
    .y_r_i  (y_r_q),
    .frac_i (pos_q[FRAC_W-1:0]),
    .cfg_i  (cfg),
    .mix_l_i(mix_l_q),
    .mix_r_i(mix_r_q),
    .done_o (dsp_done),
    .out_l_o(dsp_l),
    .out_r_o(dsp_r),
    .clip_o (dsp_clip)
  );

  // Advance by the step and clamp to the 33-bit position range.
  assign np = (POS_W+1)'(pos_q) + (POS_W+1)'(cfg.speed_step);
  always_comb begin
    if (np[POS_W] != np[POS_W-1]) begin
      np_sat = np[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      np_sat = np[POS_W-1:0];
    end
  end

  assign wrap_in = (state_q == S_IDLE) ? start_position_i : np_sat;

  lcr_wrap u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(wrap_start),
    .pos_i  (wrap_in),
    .cfg_i  (cfg),
    .done_o (wrap_done),
    .pos_o  (wrap_out)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (act)
            ACT_SETPOS: state_d = S_WRAP;
            ACT_RENDER: state_d = S_READ;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_READ: if (cnt_q == 3'd5) state_d = S_DSP;
      S_DSP:  if (dsp_done) state_d = S_WRAP;
      S_WRAP: if (wrap_done) state_d = render_q ? S_OUT : S_IDLE;
      S_OUT:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    rd_issue   = (state_q == S_READ) && !cnt_q[2];
    store_en   = store_we || rd_issue;
    dsp_start  = (state_q == S_READ) && (cnt_q == 3'd5);
    wrap_start = (in_acc && (act == ACT_SETPOS)) || ((state_q == S_DSP) && dsp_done);
    out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      render_q    <= 1'b0;
      cnt_q       <= 3'd0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_issue;
      if (wrap_done) pos_q <= wrap_out;
      if (in_acc) begin
        render_q <= (act == ACT_RENDER);
        cnt_q    <= 3'd0;
      end else if (state_q == S_READ) begin
        cnt_q <= cnt_q + 3'd1;
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (act == ACT_RENDER)) begin
      mix_l_q <= mix_left_i;
      mix_r_q <= mix_right_i;
    end
    if (rd_issue) begin
      slot_q    <= cnt_q[1:0];
      slot_ok_q <= rd_ok;
    end
    // Neighbors outside the valid source read as silence.
    if (pend_q) begin
      y_l_q[slot_q] <= slot_ok_q ? $signed(rdata[2*SB-1:SB]) : '0;
      y_r_q[slot_q] <= slot_ok_q ? $signed(rdata[SB-1:0]) : '0;
    end
    if (out_load) begin
      out_left_o  <= dsp_l;
      out_right_o <= dsp_r;
      clipped_o   <= dsp_clip;
    end
  end

  assign out_valid_o = out_valid_q;

  a_dsp_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dsp_done |-> state_q == S_DSP)
    else $error("interpolator finished outside its wait state");

  a_wrap_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_done |-> state_q == S_WRAP)
    else $error("wrap unit finished outside its wait state");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT && $past(render_q))
    else $error("result raised without a finished render");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives load, set-position, render and no-op items with random idling on both sides.
// A scoreboard predicts every rendered frame and compares its left, right and clip fields.
// ----------------------------------------------------------------------------
class frame_scoreboard;
  logic signed [15:0] left_mem[int];
  logic signed [15:0] right_mem[int];
  longint position;
  longint speed_step;
  bit loop_enable;
  longint loop_start, loop_end, source_length;
  bit mono_source;
  longint gain_left, gain_right;
  logic [32:0] frame_q[$];
  int errors;
  int shown;

  function new();
    position = 0; speed_step = 65536; loop_enable = 0; loop_start = 0;
    loop_end = 65536; source_length = 0; mono_source = 0;
    gain_left = 16384; gain_right = 16384; errors = 0; shown = 0;
  endfunction

  function void set_reg(lcr_pkg::reg_idx_e idx, logic [31:0] v);
    case (idx)
      lcr_pkg::REG_SPEED_STEP: speed_step = longint'($signed(v[24:0]));
      lcr_pkg::REG_LOOP_ENABLE: loop_enable = v[0];
      lcr_pkg::REG_LOOP_START: loop_start = v[15:0];
      lcr_pkg::REG_LOOP_END: loop_end = v[16:0];
      lcr_pkg::REG_SOURCE_LENGTH: source_length = v[16:0];
      lcr_pkg::REG_MONO_SOURCE: mono_source = v[0];
      lcr_pkg::REG_GAIN_LEFT: gain_left = v[15:0];
      default: gain_right = v[15:0];
    endcase
  endfunction

  function longint floor_shift(longint x, int n);
    return x >>> n;
  endfunction

  function longint round_shift(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function longint fold(longint p);
    longint len, span, rel;
    len = loop_end - loop_start;
    if (!loop_enable || len <= 1) return p;
    span = len * 65536;
    rel = (p - loop_start * 65536) % span;
    if (rel < 0) rel += span;
    return loop_start * 65536 + rel;
  endfunction

  function longint fetch(bit right, longint idx);
    if (idx < 0 || idx >= source_length || idx >= 65536) return 0;
    return right ? longint'(right_mem[int'(idx)]) : longint'(left_mem[int'(idx)]);
  endfunction

  function longint hermite(bit right);
    longint f, i1, y0, y1, y2, y3, acc;
    f = position & 64'hFFFF;
    i1 = floor_shift(position, 16);
    y0 = fetch(right, i1 - 1); y1 = fetch(right, i1);
    y2 = fetch(right, i1 + 1); y3 = fetch(right, i1 + 2);
    acc = y3 - y0 + 3 * (y1 - y2);
    acc = round_shift(acc * f, 16) + 2 * y0 - 5 * y1 + 4 * y2 - y3;
    acc = round_shift(acc * f, 16) + y2 - y0;
    acc = round_shift(acc * f, 16) + 2 * y1;
    return round_shift(acc, 1);
  endfunction

  function longint blend(longint v, longint g, longint mix, ref bit clip);
    longint s;
    s = round_shift(v * g, 14) + mix;
    if (s > 32767) begin clip = 1; return 32767; end
    if (s < -32768) begin clip = 1; return -32768; end
    return s;
  endfunction

  // Notes an accepted input item and queues the frame it produces, if any.
  function void note_item(lcr_pkg::action_e act, logic [15:0] addr,
                          logic signed [15:0] ll, logic signed [15:0] lr,
                          logic signed [32:0] sp, logic signed [15:0] ml,
                          logic signed [15:0] mr);
    longint vl, vr, ol, orr, np;
    bit clip;
    case (act)
      lcr_pkg::ACT_LOAD: begin
        left_mem[int'(addr)] = ll; right_mem[int'(addr)] = lr;
      end
      lcr_pkg::ACT_SETPOS: position = fold(longint'(sp));
      lcr_pkg::ACT_RENDER: begin
        clip = 0;
        vl = hermite(0);
        vr = mono_source ? vl : hermite(1);
        ol = blend(vl, gain_left, ml, clip);
        orr = blend(vr, gain_right, mr, clip);
        np = position + speed_step;
        if (np > 64'sd4294967295) np = 64'sd4294967295;
        if (np < -64'sd4294967296) np = -64'sd4294967296;
        position = fold(np);
        frame_q.push_back({ol[15:0], orr[15:0], clip});
      end
      default: ;
    endcase
  endfunction

  function void check_frame(logic [15:0] l, logic [15:0] r, logic c);
    logic [32:0] exp_f;
    if (frame_q.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected frame %h %h %b", l, r, c);
      end
      return;
    end
    exp_f = frame_q.pop_front();
    if (exp_f !== {l, r, c}) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("frame mismatch: expected L %h R %h clip %b, got L %h R %h clip %b",
                 exp_f[32:17], exp_f[16:1], exp_f[0], l, r, c);
      end
    end
  endfunction
endclass

module testbench;
  import lcr_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [1:0] action_i = '0;
  logic [15:0] sample_address_i = '0;
  logic signed [15:0] load_left_i = '0, load_right_i = '0;
  logic signed [32:0] start_position_i = '0;
  logic signed [15:0] mix_left_i = '0, mix_right_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic signed [15:0] out_left_o, out_right_o;
  logic clipped_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint src_len;
  frame_scoreboard sb;

  looping_cubic_resampler_core u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_frame(out_left_o, out_right_o, clipped_o);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Valid stays high from one item to the next; it drops only for idling,
  // for register writes and while draining.
  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    in_valid_i <= 0;
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= PADDR_W'(4 * idx); pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, v);
    if (idx == REG_SOURCE_LENGTH) src_len = v[16:0];
    @(posedge clk_i);
  endtask

  task automatic send_item(action_e act, logic [15:0] addr, logic signed [15:0] ll,
                           logic signed [15:0] lr, logic signed [32:0] sp,
                           logic signed [15:0] ml, logic signed [15:0] mr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1; action_i <= act; sample_address_i <= addr;
    load_left_i <= ll; load_right_i <= lr; start_position_i <= sp;
    mix_left_i <= ml; mix_right_i <= mr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, addr, ll, lr, sp, ml, mr);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 0;
    while (sb.frame_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (sb.frame_q.size() != 0) begin
      $display("simulation failed");
      $finish;
    end
    repeat (60) @(posedge clk_i);
  endtask

  // Fills samples 0..n-1 so that every in-range read hits a written entry.
  task automatic fill_source(int n);
    for (int i = 0; i < n; i++)
      send_item(ACT_LOAD, 16'(i), 16'($urandom), 16'($urandom), '0, '0, '0);
  endtask

  task automatic random_item();
    int pick;
    logic signed [32:0] sp;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_item(ACT_LOAD, 16'($urandom_range(src_len - 1)), 16'($urandom),
                16'($urandom), '0, '0, '0);
    end else if (pick < 16) begin
      if ($urandom_range(3) == 0) sp = {$urandom, 1'($urandom)};
      else sp = 33'($urandom_range(src_len * 65536 + 131072)) - 33'sd65536;
      send_item(ACT_SETPOS, 16'($urandom), 16'($urandom), 16'($urandom), sp, '0, '0);
    end else if (pick < 18) begin
      send_item(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                {$urandom, 1'($urandom)}, 16'($urandom), 16'($urandom));
    end else begin
      send_item(ACT_RENDER, 16'($urandom), 16'($urandom), 16'($urandom),
                {$urandom, 1'($urandom)}, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int pct_set[4][2];
    sb = new();
    src_len = 0;
    pct_set = '{'{0, 0}, '{57, 0}, '{0, 57}, '{14, 14}};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part: default settings, extremes and the special cases.
    write_reg(REG_SOURCE_LENGTH, 8);
    fill_source(8);
    send_item(ACT_LOAD, 16'd3, 16'sh7FFF, 16'sh8000, '0, '0, '0);
    send_item(ACT_LOAD, 16'hFFFF, 16'sh8000, 16'sh7FFF, '0, '0, '0);
    send_item(ACT_RENDER, '0, '0, '0, '0, 16'sh7FFF, 16'sh8000);
    send_item(ACT_SETPOS, '0, '0, '0, 33'sh0_0002_8000, '0, '0);
    send_item(ACT_RENDER, '0, '0, '0, '0, 16'sh0000, 16'sh0000);
    send_item(ACT_NONE, 16'hFFFF, 16'sh7FFF, 16'sh8000, 33'h1_FFFF_FFFF, '0, '0);
    send_item(ACT_SETPOS, '0, '0, '0, 33'sh1_0000_0000, '0, '0);
    send_item(ACT_RENDER, '0, '0, '0, '0, 16'sh8000, 16'sh7FFF);
    send_item(ACT_SETPOS, '0, '0, '0, 33'sh0_FFFF_FFFF, '0, '0);
    send_item(ACT_RENDER, '0, '0, '0, '0, 16'sh7FFF, 16'sh7FFF);
    send_item(ACT_SETPOS, '0, '0, '0, 33'sh0_0006_FFFF, '0, '0);
    send_item(ACT_RENDER, '0, '0, '0, '0, 16'sh1234, 16'shEDCB);
    drain();
    write_reg(REG_SPEED_STEP, 32'h00FF_FFFF);
    write_reg(REG_GAIN_LEFT, 32'hFFFF);
    write_reg(REG_GAIN_RIGHT, 32'hFFFF);
    write_reg(REG_MONO_SOURCE, 1);
    write_reg(REG_LOOP_ENABLE, 1);
    write_reg(REG_LOOP_START, 2);
    write_reg(REG_LOOP_END, 6);
    send_item(ACT_SETPOS, '0, '0, '0, 33'sh1_0000_0000, '0, '0);
    send_item(ACT_RENDER, '0, '0, '0, '0, 16'sh7FFF, 16'sh8000);
    send_item(ACT_RENDER, '0, '0, '0, '0, 16'sh8000, 16'sh7FFF);
    drain();
    write_reg(REG_SPEED_STEP, 32'h0100_0000);
    send_item(ACT_RENDER, '0, '0, '0, '0, '0, '0);
    send_item(ACT_RENDER, '0, '0, '0, '0, '0, '0);
    drain();

    // Random phases with varying settings and idling.
    for (int ph = 0; ph < 16; ph++) begin
      send_idle_pct = pct_set[ph % 4][0];
      recv_stall_pct = pct_set[ph % 4][1];
      write_reg(REG_SOURCE_LENGTH, (ph == 15) ? 32'd65536 : 32'($urandom_range(4, 64)));
      write_reg(REG_SPEED_STEP, (ph == 3) ? 32'h0100_0000 :
                32'($signed($urandom_range(0, 393216)) - 196608));
      write_reg(REG_LOOP_ENABLE, 32'(ph % 3 != 0));
      write_reg(REG_LOOP_START, (ph == 7) ? 32'hFFFF : 32'($urandom_range(src_len)));
      write_reg(REG_LOOP_END, (ph == 5) ? 32'h10000 : 32'($urandom_range(src_len + 2)));
      write_reg(REG_MONO_SOURCE, 32'($urandom_range(1)));
      write_reg(REG_GAIN_LEFT, (ph == 2) ? 32'd0 : 32'($urandom_range(65535)));
      write_reg(REG_GAIN_RIGHT, (ph == 2) ? 32'hFFFF : 32'($urandom_range(65535)));
      if (src_len > 64) fill_source(64);
      else fill_source(int'(src_len));
      if (src_len > 64) write_reg(REG_SOURCE_LENGTH, 64);
      for (int k = 0; k < 90; k++) random_item();
      drain();
    end

    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: looping_cubic_resampler_core.f
hdl/lcr_pkg.sv
hdl/lcr_regs.sv
hdl/lcr_store.sv
hdl/lcr_wrap.sv
hdl/lcr_dsp.sv
hdl/looping_cubic_resampler_core.sv
test/testbench.sv
